// File: rtl/mrsa_pkg.sv
package mrsa_pkg;

  localparam logic [7:0] RealtimeBase = 8'hF8;
  localparam logic [7:0] SysexStart   = 8'hF0;
  localparam logic [7:0] SysexEnd     = 8'hF7;
  localparam logic [7:0] TuneRequest  = 8'hF6;
  localparam logic [7:0] StatusBit    = 8'h80;
  localparam logic [15:0] DropMax     = 16'hFFFF;

  typedef struct packed {
    logic        in_sysex;
    logic [7:0]  running_status;
    logic [7:0]  held_status;
    logic [6:0]  held_first_data;
    logic [1:0]  collected_count;
    logic [1:0]  needed_count;
    logic [15:0] dropped_counter;
  } state_t;

  typedef struct packed {
    logic        msg_valid;
    logic [1:0]  msg_length;
    logic [7:0]  status_byte;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
    logic        byte_dropped;
    logic [15:0] dropped_total;
  } result_t;

  function automatic logic [1:0] msg_len(input logic [7:0] s);
    logic [1:0] n;
    n = 2'd0;
    if (s >= RealtimeBase) begin
      n = 2'd1;
    end else if (s < StatusBit) begin
      n = 2'd0;
    end else if (s < SysexStart) begin
      n = (s[7:4] == 4'hC || s[7:4] == 4'hD) ? 2'd2 : 2'd3;
    end else begin
      case (s)
        8'hF1, 8'hF3: n = 2'd2;
        8'hF2:        n = 2'd3;
        TuneRequest:  n = 2'd1;
        default:      n = 2'd0;
      endcase
    end
    return n;
  endfunction

endpackage

// File: rtl/mrsa_step.sv
module mrsa_step (
  input  mrsa_pkg::state_t   state_i,
  input  logic [7:0]         data_byte_i,
  output mrsa_pkg::state_t   state_o,
  output mrsa_pkg::result_t  result_o
);

  logic [1:0] n;
  logic       check;
  logic [1:0] coll;
  logic [1:0] need;
  mrsa_pkg::state_t  s;
  mrsa_pkg::result_t r;

  assign n = mrsa_pkg::msg_len(data_byte_i);

  always_comb begin
    s     = state_i;
    r     = '0;
    check = 1'b1;
    coll  = 2'd0;
    need  = 2'd0;
    if (data_byte_i >= mrsa_pkg::RealtimeBase) begin
      r.msg_valid   = 1'b1;
      r.msg_length  = 2'd1;
      r.status_byte = data_byte_i;
    end else if (state_i.in_sysex) begin
      if (data_byte_i == mrsa_pkg::SysexEnd) begin
        s.in_sysex = 1'b0;
      end
    end else if (data_byte_i[7]) begin
      s.collected_count = 2'd0;
      s.needed_count    = 2'd0;
      if (data_byte_i == mrsa_pkg::SysexStart) begin
        s.in_sysex       = 1'b1;
        s.running_status = 8'h00;
      end else if (n == 2'd0) begin
        if (data_byte_i >= mrsa_pkg::SysexStart) begin
          s.running_status = 8'h00;
        end
      end else begin
        s.running_status = (data_byte_i < mrsa_pkg::SysexStart) ? data_byte_i : 8'h00;
        if (n == 2'd1) begin
          r.msg_valid   = 1'b1;
          r.msg_length  = 2'd1;
          r.status_byte = data_byte_i;
        end else begin
          s.held_status     = data_byte_i;
          s.collected_count = 2'd1;
          s.needed_count    = n;
        end
      end
    end else begin
      case (state_i.collected_count)
        2'd0: begin
          if (state_i.running_status == 8'h00) begin
            check = 1'b0;
          end else begin
            s.held_status     = state_i.running_status;
            s.held_first_data = data_byte_i[6:0];
            s.collected_count = 2'd2;
            s.needed_count    = mrsa_pkg::msg_len(state_i.running_status);
          end
        end
        2'd1: begin
          s.held_first_data = data_byte_i[6:0];
          s.collected_count = 2'd2;
        end
        2'd2: begin
          s.collected_count = 2'd3;
        end
        default: begin
          s.collected_count = 2'd0;
          s.needed_count    = 2'd0;
          check             = 1'b0;
        end
      endcase
      if (!check) begin
        r.byte_dropped = 1'b1;
        if (state_i.dropped_counter != mrsa_pkg::DropMax) begin
          s.dropped_counter = state_i.dropped_counter + 16'd1;
        end
      end
      coll = s.collected_count;
      need = s.needed_count;
      if (check && need != 2'd0 && coll >= need) begin
        r.msg_valid   = 1'b1;
        r.msg_length  = coll;
        r.status_byte = s.held_status;
        if (coll == 2'd2) begin
          r.first_data = data_byte_i[6:0];
        end else begin
          r.first_data  = s.held_first_data;
          r.second_data = data_byte_i[6:0];
        end
        s.collected_count = 2'd0;
        s.needed_count    = 2'd0;
      end
    end
    r.dropped_total = s.dropped_counter;
    state_o  = s;
    result_o = r;
  end

endmodule

// File: rtl/midi_running_status_assembler.sv
// A byte accepted into the input register is decoded combinationally, and its result is
// captured in the output register when that register is not stalled.
// Throughput: one byte per cycle while the output is not stalled. While a result is stalled in the output register,
// the input register takes one more byte and then stalls.
// Reset: rst_ni clears the parser state, the drop counter and both valid flags
// at once, asynchronously.
module midi_running_status_assembler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        msg_valid_o,
  output logic [1:0]  msg_length_o,
  output logic [7:0]  status_byte_o,
  output logic [6:0]  first_data_o,
  output logic [6:0]  second_data_o,
  output logic        byte_dropped_o,
  output logic [15:0] dropped_total_o
);

  logic              in_valid_q;
  logic [7:0]        byte_q;
  logic              out_valid_q;
  logic              advance;
  mrsa_pkg::state_t  state_q;
  mrsa_pkg::state_t  state_d;
  mrsa_pkg::result_t result_q;
  mrsa_pkg::result_t result_d;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;

  mrsa_step u_step (
    .state_i     (state_q),
    .data_byte_i (byte_q),
    .state_o     (state_d),
    .result_o    (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      byte_q <= data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign msg_valid_o     = result_q.msg_valid;
  assign msg_length_o    = result_q.msg_length;
  assign status_byte_o   = result_q.status_byte;
  assign first_data_o    = result_q.first_data;
  assign second_data_o   = result_q.second_data;
  assign byte_dropped_o  = result_q.byte_dropped;
  assign dropped_total_o = result_q.dropped_total;

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a waiting result");

  a_msg_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && msg_valid_o) |-> (msg_length_o != 2'd0))
    else $error("completed message has zero length");

  a_drop_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && byte_dropped_o) |-> !msg_valid_o)
    else $error("dropped byte also completed a message");

  a_count_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.dropped_counter >= $past(state_q.dropped_counter))
    else $error("drop counter decreased");

endmodule
